### hdl/prht_pkg.sv
// Shared types and constants for the pointer region hit test block.
package prht_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int ADDR_W      = $clog2(MAX_REGIONS);
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int FRAC_BITS   = 8;
	localparam int ROT_FRAC    = 14;

	typedef enum logic [2:0] {
		OP_BOUNDS  = 3'd0,
		OP_BASE    = 3'd1,
		OP_ROT     = 3'd2,
		OP_COUNT   = 3'd3,
		OP_POINTER = 3'd4
	} op_t;

	// Entry written by a bounds beat
	typedef struct packed {
		logic [2:0]         rflags;   // bit2 transform, bit1 visible, bit0 enabled
		logic [15:0]        key;
		logic signed [23:0] bh;
		logic signed [23:0] bw;
		logic signed [23:0] by;
		logic signed [23:0] bx;
	} bounds_t;

	// Entry written by a base rectangle beat
	typedef struct packed {
		logic signed [23:0] pvy;
		logic signed [23:0] pvx;
		logic signed [23:0] gh;
		logic signed [23:0] gw;
		logic signed [23:0] gy;
		logic signed [23:0] gx;
	} base_t;

	// Entry written by a rotation and scale beat
	typedef struct packed {
		logic               scale_ok;
		logic signed [23:0] isy;
		logic signed [23:0] isx;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
	} rot_t;

	// Pointer event held between front and back
	typedef struct packed {
		logic [2:0]         flags;    // bit0 pressed, bit1 released, bit2 down
		logic signed [23:0] py;
		logic signed [23:0] px;
	} event_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_BOX,
		ST_MUL,
		ST_ROT,
		ST_SCL,
		ST_CMP,
		ST_DONE
	} back_state_t;

endpackage

### hdl/prht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hdl/prht_front.sv
// Front end: accepts beats, writes the region table, queues pointer events.
module prht_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [2:0]                  op,
	input  logic [6:0]                  slot,
	input  logic signed [23:0]          wx,
	input  logic signed [23:0]          wy,
	input  logic signed [23:0]          ww,
	input  logic signed [23:0]          wh,
	input  logic signed [23:0]          kp,
	input  logic signed [23:0]          pvy,
	input  logic [2:0]                  flags,
	input  prht_pkg::back_stat_t        stat,
	output logic                        ev_valid,
	output prht_pkg::event_t            ev_head,
	output logic [prht_pkg::CNT_W-1:0]  count,
	output logic                        we_a,
	output logic                        we_b,
	output logic                        we_c,
	output logic [prht_pkg::ADDR_W-1:0] waddr,
	output prht_pkg::bounds_t           wdata_a,
	output prht_pkg::base_t             wdata_b,
	output prht_pkg::rot_t              wdata_c
);
	import prht_pkg::*;

	event_t              fifo_q [2];
	logic                wp_q, rp_q;
	logic [1:0]          fill_q;
	logic [CNT_W-1:0]    count_q;
	logic                acc, push, slot_ok, quiet;
	logic signed [15:0]  cs_sat, sn_sat;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7fff;
		end else if (v < -24'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	assign quiet    = (fill_q == 2'd0) && !stat.busy;
	// pointer events only need queue room; table writes wait for the back end to drain
	assign s_tready = (op == OP_POINTER) ? (fill_q != 2'd2) : quiet;
	assign acc      = s_tvalid && s_tready;
	assign push     = acc && (op == OP_POINTER);
	assign slot_ok  = slot < CNT_W'(MAX_REGIONS);

	assign cs_sat = sat16(wx);
	assign sn_sat = sat16(wy);

	assign waddr   = slot[ADDR_W-1:0];
	assign we_a    = acc && slot_ok && (op == OP_BOUNDS);
	assign we_b    = acc && slot_ok && (op == OP_BASE);
	assign we_c    = acc && slot_ok && (op == OP_ROT);
	assign wdata_a = '{rflags: flags, key: kp[15:0], bh: wh, bw: ww, by: wy, bx: wx};
	assign wdata_b = '{pvy: pvy, pvx: kp, gh: wh, gw: ww, gy: wy, gx: wx};
	assign wdata_c = '{scale_ok: flags[0], isy: wh, isx: ww, sn: sn_sat, cs: cs_sat};

	assign ev_valid = fill_q != 2'd0;
	assign ev_head  = fifo_q[rp_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{flags: flags, py: wy, px: wx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			fill_q  <= 2'd0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (stat.pop) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(stat.pop);
			if (acc && op == OP_COUNT) begin
				count_q <= (slot > 7'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : CNT_W'(slot);
			end
		end
	end
endmodule

### hdl/prht_back.sv
// Back end: walks the regions for one pointer event and applies the click rule.
module prht_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ev_valid,
	input  prht_pkg::event_t            ev_head,
	input  logic [prht_pkg::CNT_W-1:0]  count,
	output prht_pkg::back_stat_t        stat,
	output logic                        re,
	output logic [prht_pkg::ADDR_W-1:0] raddr,
	input  prht_pkg::bounds_t           rd_a,
	input  prht_pkg::base_t             rd_b,
	input  prht_pkg::rot_t              rd_c,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [47:0]                 m_tdata
);
	import prht_pkg::*;

	back_state_t        state_q, state_d;
	event_t             ev_q;
	logic [CNT_W-1:0]   idx_q, idx_m1;
	logic [15:0]        key_q, hov_q, pk_q;
	logic signed [23:0] pvx_q, pvy_q, gw_q, gh_q, isx_q, isy_q, rx_q, ry_q;
	logic signed [15:0] cs_q, sn_q;
	logic signed [25:0] dx_q, dy_q;
	logic signed [41:0] pxc_q, pys_q, pxs_q, pyc_q;
	logic signed [47:0] sx_q, sy_q;
	logic               out_valid_q, out_free;
	logic [47:0]        out_q;
	logic               box_ok, base_ok, in_x, in_y, last;
	logic signed [24:0] bxe, bye, lx, ly;
	logic signed [25:0] dx_d, dy_d;
	logic signed [42:0] tx, ty;
	logic [15:0]        pk_n, clk_n, held_n;

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -48'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	assign idx_m1   = idx_q - CNT_W'(1);
	assign raddr    = idx_m1[ADDR_W-1:0];
	assign re       = state_q == ST_RD;
	assign out_free = !out_valid_q || m_tready;
	assign last     = idx_q == '0;

	// box test, exact
	assign bxe    = 25'(rd_a.bx) + 25'(rd_a.bw);
	assign bye    = 25'(rd_a.by) + 25'(rd_a.bh);
	assign box_ok = (rd_a.rflags[1:0] == 2'b11) && (ev_q.px >= rd_a.bx) &&
	                (25'(ev_q.px) <= bxe) && (ev_q.py >= rd_a.by) && (25'(ev_q.py) <= bye);
	assign base_ok = (rd_b.gw > 24'sd0) && (rd_b.gh > 24'sd0) && rd_c.scale_ok;
	assign dx_d    = 26'(ev_q.px) - 26'(rd_b.gx) - 26'(rd_b.pvx);
	assign dy_d    = 26'(ev_q.py) - 26'(rd_b.gy) - 26'(rd_b.pvy);

	// rotate: floor shift by the Q1.14 fraction
	assign tx = 43'(pxc_q) - 43'(pys_q);
	assign ty = 43'(pxs_q) + 43'(pyc_q);

	// unscale and add the pivot back
	assign lx   = 25'(sat24(sx_q >>> FRAC_BITS)) + 25'(pvx_q);
	assign ly   = 25'(sat24(sy_q >>> FRAC_BITS)) + 25'(pvy_q);
	assign in_x = (lx >= 25'sd0) && (lx <= 25'(gw_q));
	assign in_y = (ly >= 25'sd0) && (ly <= 25'(gh_q));

	// click rule: press first, then release
	always_comb begin
		pk_n   = ev_q.flags[0] ? hov_q : pk_q;
		clk_n  = (ev_q.flags[1] && pk_n != 16'd0 && pk_n == hov_q) ? pk_n : 16'd0;
		pk_n   = ev_q.flags[1] ? 16'd0 : pk_n;
		held_n = ev_q.flags[2] ? pk_n : 16'd0;
	end

	always_comb begin
		state_d  = state_q;
		stat.pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (ev_valid) begin
					stat.pop = 1'b1;
					state_d  = (count == '0) ? ST_DONE : ST_RD;
				end
			end
			ST_RD:  state_d = ST_BOX;
			ST_BOX: begin
				if (box_ok && !rd_a.rflags[2]) begin
					state_d = ST_DONE;
				end else if (box_ok && base_ok) begin
					state_d = ST_MUL;
				end else begin
					state_d = last ? ST_DONE : ST_RD;
				end
			end
			ST_MUL: state_d = ST_ROT;
			ST_ROT: state_d = ST_SCL;
			ST_SCL: state_d = ST_CMP;
			ST_CMP: begin
				if (in_x && in_y) begin
					state_d = ST_DONE;
				end else begin
					state_d = last ? ST_DONE : ST_RD;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		stat.busy = state_q != ST_IDLE;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ev_q  <= ev_head;
				hov_q <= 16'd0;
			end
			ST_BOX: begin
				key_q <= rd_a.key;
				pvx_q <= rd_b.pvx;
				pvy_q <= rd_b.pvy;
				gw_q  <= rd_b.gw;
				gh_q  <= rd_b.gh;
				cs_q  <= rd_c.cs;
				sn_q  <= rd_c.sn;
				isx_q <= rd_c.isx;
				isy_q <= rd_c.isy;
				dx_q  <= dx_d;
				dy_q  <= dy_d;
				if (box_ok && !rd_a.rflags[2]) begin
					hov_q <= rd_a.key;
				end
			end
			ST_MUL: begin
				pxc_q <= dx_q * cs_q;
				pys_q <= dy_q * sn_q;
				pxs_q <= dx_q * sn_q;
				pyc_q <= dy_q * cs_q;
			end
			ST_ROT: begin
				rx_q <= sat24(48'(tx >>> ROT_FRAC));
				ry_q <= sat24(48'(ty >>> ROT_FRAC));
			end
			ST_SCL: begin
				sx_q <= rx_q * isx_q;
				sy_q <= ry_q * isy_q;
			end
			ST_CMP: begin
				if (in_x && in_y) begin
					hov_q <= key_q;
				end
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_q <= {held_n, clk_n, hov_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pk_q        <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && ev_valid) begin
				idx_q <= count;
			end else if (state_q == ST_RD) begin
				idx_q <= idx_m1;
			end
			if (state_q == ST_DONE && out_free) begin
				pk_q        <= pk_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
endmodule

### hdl/pointer_region_hit_test_click_top.sv
// Top level of the pointer region hit test with click tracking.
// The block holds up to 64 screen regions in three RAMs (bounds and key, base rectangle
// with pivot, rotation and reciprocal scale). Table writes and the set-count beat are taken
// only once all queued pointer events are finished; pointer events enter a two-deep queue.
// Each pointer event walks the active regions from the highest index down and stops at the
// first hit: each region takes a RAM read and a box test, and when the box hits a region
// with a transform and a valid base the rotated test follows (multiply, rotate shift,
// scale multiply, compare; two multiply stages, each followed by a register). A result
// beat is sent for each pointer event only; the output register lets the next event
// start while a result waits. Coordinates are Q15.8, cosine and sine Q1.14; intermediate
// values saturate.
module pointer_region_hit_test_click_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,   // slot[6:0], word_x, word_y, word_w, word_h,
	                                // key_or_pivot_x, pivot_y (24 each), flags[2:0], zero pad
	input  logic [2:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [47:0]  m_tdata    // hovered_key, clicked_key, held_key (16 each)
);
	import prht_pkg::*;

	back_stat_t        stat;
	logic              ev_valid, we_a, we_b, we_c, re;
	event_t            ev_head;
	logic [CNT_W-1:0]  count;
	logic [ADDR_W-1:0] waddr, raddr;
	bounds_t           wdata_a, rd_a;
	base_t             wdata_b, rd_b;
	rot_t              wdata_c, rd_c;

	prht_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.slot     (s_tdata[6:0]),
		.wx       (s_tdata[30:7]),
		.wy       (s_tdata[54:31]),
		.ww       (s_tdata[78:55]),
		.wh       (s_tdata[102:79]),
		.kp       (s_tdata[126:103]),
		.pvy      (s_tdata[150:127]),
		.flags    (s_tdata[153:151]),
		.stat     (stat),
		.ev_valid (ev_valid),
		.ev_head  (ev_head),
		.count    (count),
		.we_a     (we_a),
		.we_b     (we_b),
		.we_c     (we_c),
		.waddr    (waddr),
		.wdata_a  (wdata_a),
		.wdata_b  (wdata_b),
		.wdata_c  (wdata_c)
	);

	// region table
	prht_ram #(.WIDTH($bits(bounds_t)), .DEPTH(MAX_REGIONS)) u_ram_bounds (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata_a),
		.re(re), .raddr(raddr), .rdata(rd_a)
	);
	prht_ram #(.WIDTH($bits(base_t)), .DEPTH(MAX_REGIONS)) u_ram_base (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata_b),
		.re(re), .raddr(raddr), .rdata(rd_b)
	);
	prht_ram #(.WIDTH($bits(rot_t)), .DEPTH(MAX_REGIONS)) u_ram_rot (
		.clk(clk), .we(we_c), .waddr(waddr), .wdata(wdata_c),
		.re(re), .raddr(raddr), .rdata(rd_c)
	);

	prht_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_head  (ev_head),
		.count    (count),
		.stat     (stat),
		.re       (re),
		.raddr    (raddr),
		.rd_a     (rd_a),
		.rd_b     (rd_b),
		.rd_c     (rd_c),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule

### tb/sv/testbench.sv
// Stream testbench for the pointer region hit test with click tracking.
`timescale 1ns / 100ps

module testbench;
	import prht_pkg::*;

	typedef struct {
		logic [2:0]         op;
		logic [6:0]         slot;
		logic signed [23:0] wx, wy, ww, wh, kp, pvy;
		logic [2:0]         fl;
	} beat_t;

	typedef struct {
		logic [15:0] hov, clk_key, held;
	} hit_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [47:0]  m_tdata;
	logic         s_taken = 1'b0;  // beat accepted at the last rising edge

	pointer_region_hit_test_click_top dut (.*);

	always #1 clk = ~clk;

	// predictor state, mirrors the region table
	bounds_t     bnd_mem [MAX_REGIONS];
	base_t       base_mem[MAX_REGIONS];
	rot_t        rot_mem [MAX_REGIONS];
	logic [6:0]  n_active;
	logic [15:0] press_key;
	bit          written[MAX_REGIONS];

	beat_t pending_beats[$];
	hit_t  expected_hits[$];
	int    fails = 0;
	bit    calm = 0;      // no idling in the last part
	bit    hold_send = 0; // sender pause until drained
	int    s_gap = 0, r_gap = 0;

	function automatic logic signed [63:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	// arithmetic shift right floors for negative values
	function automatic bit base_holds(input int i, input logic signed [63:0] px,
			input logic signed [63:0] py);
		logic signed [63:0] dx, dy, rx, ry, lx, ly;
		base_t g;
		rot_t  r;
		g = base_mem[i];
		r = rot_mem[i];
		if (g.gw <= 0 || g.gh <= 0 || !r.scale_ok) return 0;
		dx = px - g.gx - g.pvx;
		dy = py - g.gy - g.pvy;
		rx = sat24((dx * r.cs - dy * r.sn) >>> ROT_FRAC);
		ry = sat24((dx * r.sn + dy * r.cs) >>> ROT_FRAC);
		lx = sat24((rx * r.isx) >>> FRAC_BITS) + g.pvx;
		ly = sat24((ry * r.isy) >>> FRAC_BITS) + g.pvy;
		return lx >= 0 && lx <= g.gw && ly >= 0 && ly <= g.gh;
	endfunction

	function automatic logic [15:0] topmost_key(input logic signed [63:0] px,
			input logic signed [63:0] py);
		bounds_t b;
		for (int i = int'(n_active) - 1; i >= 0; i--) begin
			b = bnd_mem[i];
			if (b.rflags[1:0] != 2'b11) continue;
			if (px < b.bx || px > 64'(b.bx) + b.bw || py < b.by || py > 64'(b.by) + b.bh)
				continue;
			if (!b.rflags[2] || base_holds(i, px, py)) return b.key;
		end
		return 16'd0;
	endfunction

	task automatic apply_beat(input beat_t t);
		hit_t h;
		logic signed [23:0] c, s;
		case (op_t'(t.op))
			OP_POINTER: begin
				h.hov = topmost_key(t.wx, t.wy);
				h.clk_key = 0;
				h.held = 0;
				if (t.fl[0]) press_key = h.hov;
				if (t.fl[1]) begin
					if (press_key != 0 && press_key == h.hov) h.clk_key = press_key;
					press_key = 0;
				end
				if (t.fl[2]) h.held = press_key;
				expected_hits.push_back(h);
			end
			OP_COUNT: n_active = (t.slot > MAX_REGIONS) ? 7'(MAX_REGIONS) : t.slot;
			OP_BOUNDS: if (t.slot < MAX_REGIONS)
				bnd_mem[t.slot] = '{t.fl, t.kp[15:0], t.wh, t.ww, t.wy, t.wx};
			OP_BASE: if (t.slot < MAX_REGIONS)
				base_mem[t.slot] = '{t.pvy, t.kp, t.wh, t.ww, t.wy, t.wx};
			OP_ROT: if (t.slot < MAX_REGIONS) begin
				c = t.wx > 24'sd32767 ? 24'sd32767 : (t.wx < -24'sd32768 ? -24'sd32768 : t.wx);
				s = t.wy > 24'sd32767 ? 24'sd32767 : (t.wy < -24'sd32768 ? -24'sd32768 : t.wy);
				rot_mem[t.slot] = '{t.fl[0], t.wh, t.ww, s[15:0], c[15:0]};
			end
			default: ;
		endcase
	endtask

	// note whether the beat on the bus was taken at the rising edge
	always @(posedge clk) begin
		s_taken <= s_tvalid && s_tready;
	end

	// driver: change inputs on the falling edge
	always @(negedge clk) begin
		beat_t t;
		if (arst_n) begin
			if (s_tvalid && !s_taken) begin
				// hold the beat
			end else if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0 && !(hold_send && expected_hits.size() > 0)
					&& !(s_tvalid && pending_beats.size() == 1 && 0)) begin
				t = pending_beats.pop_front();
				apply_beat(t);
				s_tdata <= {6'd0, t.fl, t.pvy, t.kp, t.wh, t.ww, t.wy, t.wx, t.slot};
				s_tuser <= t.op;
				s_tvalid <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0) s_gap <= $urandom_range(1, 15);
			end else
				s_tvalid <= 1'b0;
			if (!calm && r_gap == 0 && $urandom_range(0, 9) == 0)
				r_gap <= $urandom_range(1, 15);
			else if (r_gap > 0)
				r_gap <= r_gap - 1;
			m_tready <= calm || r_gap == 0;
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		hit_t h;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_hits.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				fails++;
			end else begin
				h = expected_hits.pop_front();
				if (m_tdata[15:0] !== h.hov) begin
					$error("hovered_key exp %0d got %0d", h.hov, m_tdata[15:0]);
					fails++;
				end
				if (m_tdata[31:16] !== h.clk_key) begin
					$error("clicked_key exp %0d got %0d", h.clk_key, m_tdata[31:16]);
					fails++;
				end
				if (m_tdata[47:32] !== h.held) begin
					$error("held_key exp %0d got %0d", h.held, m_tdata[47:32]);
					fails++;
				end
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [23:0] r24();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	// coordinate near the screen area, Q15.8
	function automatic logic signed [23:0] coord(input int lo, input int hi);
		return 24'($signed($urandom_range(0, hi - lo)) + lo);
	endfunction

	task automatic put(input op_t op, input int slot, input logic signed [23:0] x, y, w, h,
			kp, pvy, input int fl);
		beat_t t;
		t = '{op, 7'(slot), x, y, w, h, kp, pvy, 3'(fl)};
		pending_beats.push_back(t);
		if (op inside {OP_BOUNDS, OP_BASE, OP_ROT} && slot < MAX_REGIONS && op == OP_BOUNDS)
			written[slot] = 1;
	endtask

	// full region: bounds, base and rotation
	task automatic put_region(input int slot, input bit full_rand);
		int bx, by;
		bx = $urandom_range(0, 60000) - 10000;
		by = $urandom_range(0, 60000) - 10000;
		put(OP_BOUNDS, slot, bx, by, $urandom_range(0, 40000), $urandom_range(0, 40000),
			$urandom_range(0, 65535), r24(), $urandom_range(0, 7) | ($urandom_range(0, 2) ? 3 : 0));
		put(OP_BASE, slot, full_rand ? r24() : coord(bx - 2000, bx + 4000),
			full_rand ? r24() : coord(by - 2000, by + 4000),
			full_rand ? r24() : coord(-500, 30000), full_rand ? r24() : coord(-500, 30000),
			full_rand ? r24() : coord(-4000, 4000), full_rand ? r24() : coord(-4000, 4000), 0);
		put(OP_ROT, slot, full_rand ? r24() : coord(-16384, 16384),
			full_rand ? r24() : coord(-16384, 16384),
			full_rand ? r24() : coord(128, 600), full_rand ? r24() : coord(128, 600),
			0, r24(), $urandom_range(0, 7));
	endtask

	initial begin
		int items;
		int nreg;
		int s;
		n_active = 0;
		press_key = 0;
		// directed: every slot gets written before any count covers it
		for (int i = 0; i < 4; i++) put_region(i, i == 3);
		put(OP_BOUNDS, 127, 0, 0, 0, 0, 0, 0, 7);   // ignored, slot out of range
		put(OP_ROT, 64, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0, 1);
		put(OP_BASE, 100, 0, 0, 0, 0, 0, 0, 0);
		put(OP_COUNT, 4, 0, 0, 0, 0, 0, 0, 0);
		put(OP_ROT, 0, 24'sh7FFFFF, 24'sh800000, 256, 256, 0, 0, 1);  // cos/sin saturate
		put(op_t'(3'd5), 0, 0, 0, 0, 0, 0, 0, 7);  // unknown ops ignored
		put(op_t'(3'd7), 127, -1, -1, -1, -1, -1, -1, 7);
		put(OP_POINTER, 0, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0, 7);
		put(OP_POINTER, 127, 1000, 1000, 0, 0, 0, 0, 3);  // press and release at once
		put(OP_POINTER, 0, 0, 0, 0, 0, 0, 0, 1);
		put(OP_POINTER, 0, 24'sh800000, 24'sh7FFFFF, 0, 0, 0, 0, 4);
		put(OP_POINTER, 0, 0, 0, 0, 0, 0, 0, 6);
		put(OP_COUNT, 0, 0, 0, 0, 0, 0, 0, 0);
		put(OP_POINTER, 0, 0, 0, 0, 0, 0, 0, 0);
		items = pending_beats.size();
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		nreg = 4;
		while (items < 1000) begin
			// top up the table, then point at it
			if ($urandom_range(0, 3) == 0 && nreg < MAX_REGIONS) begin
				s = $urandom_range(0, 3) ? nreg : $urandom_range(0, nreg - 1);
				put_region(s, $urandom_range(0, 4) == 0);
				if (s == nreg) nreg++;
				items += 3;
			end else if ($urandom_range(0, 7) == 0) begin
				put(OP_COUNT, $urandom_range(0, 9) ? $urandom_range(0, nreg) :
					(nreg == MAX_REGIONS ? $urandom_range(64, 127) : nreg), 0, 0, 0, 0, 0, 0, 0);
				items++;
			end else if ($urandom_range(0, 19) == 0) begin
				put(op_t'($urandom_range(5, 7)), $urandom_range(0, 127), r24(), r24(), r24(),
					r24(), r24(), r24(), $urandom_range(0, 7));
			end else begin
				put(OP_POINTER, $urandom_range(0, 127),
					$urandom_range(0, 3) ? coord(-12000, 95000) : r24(),
					$urandom_range(0, 3) ? coord(-12000, 95000) : r24(),
					r24(), r24(), r24(), r24(), $urandom_range(0, 7));
				items++;
			end
			if (items > 500 && items < 504) begin
				// wait until the queue drains once before going on
				wait (pending_beats.size() == 0);
				hold_send = 1;
			end
			if (items > 850) calm = 1;
		end
		wait (pending_beats.size() == 0);
		hold_send = 0;
		wait (pending_beats.size() == 0 && expected_hits.size() == 0 && !s_tvalid);
		repeat (500) @(posedge clk);
		if (fails == 0 && expected_hits.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

### files.f
hdl/prht_pkg.sv
hdl/prht_ram.sv
hdl/prht_front.sv
hdl/prht_back.sv
hdl/pointer_region_hit_test_click_top.sv
tb/sv/testbench.sv
